// ===== rtl/core/assert_macros.svh =====
// Assertion helpers; empty in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== rtl/core/vna_pkg.sv =====
package vna_pkg;
  localparam int VERTEX_COUNT = 1024;
  localparam int IDX_W = $clog2(VERTEX_COUNT);
  localparam int POS_W = 24;
  localparam int SUM_W = 24;
  localparam int NRM_W = 16;
  localparam int VEC_W = 52;
  localparam logic signed [NRM_W-1:0] ONE_Q14 = 16'sd16384;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_TRI  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_PRD, S_MUL, S_FNORM, S_RMW, S_RDSUM, S_SNORM
  } top_state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV
  } norm_state_t;

  typedef struct packed {
    logic                    done;
    logic                    zero;
    logic                    busy;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
  } norm_res_t;
endpackage

// ===== rtl/core/vertex_normal_accumulator_top.sv =====
// Channel   Direction  Signals
// command   in         start / busy, mode, vertex_index, pos_x/y/z, corner_b, corner_c
// result    out        done, vertex_id, normal_x/y/z, used_fallback
//
// Load (mode 0) and unused mode 3 finish at the transfer edge; busy stays low.
// Triangle: position reads, then the cross product on one 25x25 multiplier, then normalize
// (with scaling shifts) and a read-modify-write of the three corner sums;
// a degenerate face is dropped in normalize. Read: a sum read, then normalize;
// done goes high as busy falls, also for a zero sum.
// Synchronous reset clears control only; memories are undefined until written.
// The receiver cannot stall; one command is in flight at a time.
`include "assert_macros.svh"
module vertex_normal_accumulator_top import vna_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              mode,
  input  logic [IDX_W-1:0]        vertex_index,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [IDX_W-1:0]        corner_b,
  input  logic [IDX_W-1:0]        corner_c,
  output logic                    done,
  output logic [IDX_W-1:0]        vertex_id,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic signed [NRM_W-1:0] normal_z,
  output logic                    used_fallback
);
  logic [3*POS_W-1:0] pos_mem [VERTEX_COUNT];
  logic [3*SUM_W-1:0] sum_mem [VERTEX_COUNT];
  logic [3*POS_W-1:0] pos_rdata;
  logic [3*SUM_W-1:0] sum_rdata;
  logic [IDX_W-1:0] pos_raddr, sum_addr;
  logic sum_we;
  logic [3*SUM_W-1:0] sum_wdata;

  top_state_t state, state_next;
  logic [2:0] cnt;
  logic [IDX_W-1:0] ia, ib, ic;
  logic signed [POS_W-1:0] p [3][3];
  logic signed [49:0] prod;
  logic signed [VEC_W-1:0] cr [3];
  logic signed [POS_W:0] ma, mb;
  logic signed [POS_W:0] e1 [3], e2 [3];
  logic norm_go;
  logic signed [VEC_W-1:0] vx, vy, vz;
  norm_res_t nr;
  logic accept, load_we;
  logic signed [SUM_W:0] s_add [3];
  logic signed [SUM_W-1:0] s_sat [3];

  assign accept = start && !busy;
  assign load_we = accept && (mode == MODE_LOAD);
  assign busy = (state != S_IDLE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = (POS_W+1)'(p[1][i]) - (POS_W+1)'(p[0][i]);
      e2[i] = (POS_W+1)'(p[2][i]) - (POS_W+1)'(p[0][i]);
    end
    case (cnt)
      3'd0:    begin ma = e1[1]; mb = e2[2]; end
      3'd1:    begin ma = e1[2]; mb = e2[1]; end
      3'd2:    begin ma = e1[2]; mb = e2[0]; end
      3'd3:    begin ma = e1[0]; mb = e2[2]; end
      3'd4:    begin ma = e1[0]; mb = e2[1]; end
      default: begin ma = e1[1]; mb = e2[0]; end
    endcase
    case (cnt)
      3'd0:    pos_raddr = ia;
      3'd1:    pos_raddr = ib;
      default: pos_raddr = ic;
    endcase
    case (cnt[2:1])
      2'd0:    sum_addr = (state == S_RMW) ? ia : vertex_index;
      2'd1:    sum_addr = ib;
      default: sum_addr = ic;
    endcase
    if (state == S_RDSUM) sum_addr = ia;
    if (state == S_IDLE) sum_addr = vertex_index;
    s_add[0] = (SUM_W+1)'($signed(sum_rdata[3*SUM_W-1:2*SUM_W])) + (SUM_W+1)'(nr.nx);
    s_add[1] = (SUM_W+1)'($signed(sum_rdata[2*SUM_W-1:SUM_W])) + (SUM_W+1)'(nr.ny);
    s_add[2] = (SUM_W+1)'($signed(sum_rdata[SUM_W-1:0])) + (SUM_W+1)'(nr.nz);
    for (int i = 0; i < 3; i++) begin
      if (s_add[i][SUM_W] != s_add[i][SUM_W-1])
        s_sat[i] = s_add[i][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                   : {1'b0, {(SUM_W-1){1'b1}}};
      else
        s_sat[i] = s_add[i][SUM_W-1:0];
    end
    sum_we = load_we || (state == S_RMW && cnt[0]);
    sum_wdata = load_we ? '0 : {s_sat[0], s_sat[1], s_sat[2]};
    if (state == S_RMW && cnt[0]) begin
      case (cnt[2:1])
        2'd0:    sum_addr = ia;
        2'd1:    sum_addr = ib;
        default: sum_addr = ic;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) pos_mem[vertex_index] <= {pos_x, pos_y, pos_z};
    pos_rdata <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_addr] <= sum_wdata;
    sum_rdata <= sum_mem[sum_addr];
  end

  always_comb begin
    state_next = state;
    norm_go = 1'b0;
    vx = cr[0];
    vy = cr[1];
    vz = cr[2];
    case (state)
      S_IDLE: begin
        if (accept && mode == MODE_TRI) state_next = S_PRD;
        else if (accept && mode == MODE_READ) state_next = S_RDSUM;
      end
      S_PRD:  if (cnt == 3'd3) state_next = S_MUL;
      S_MUL:  if (cnt == 3'd6) state_next = S_FNORM;
      S_FNORM: begin
        norm_go = (cnt == 3'd0);
        if (nr.done) state_next = nr.zero ? S_IDLE : S_RMW;
      end
      S_RMW:  if (cnt == 3'd5) state_next = S_IDLE;
      S_RDSUM: begin
        norm_go = 1'b1;
        vx = VEC_W'($signed(sum_rdata[3*SUM_W-1:2*SUM_W]));
        vy = VEC_W'($signed(sum_rdata[2*SUM_W-1:SUM_W]));
        vz = VEC_W'($signed(sum_rdata[SUM_W-1:0]));
        state_next = S_SNORM;
      end
      S_SNORM: if (nr.done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_SNORM) && nr.done;
    end
  end

  always_ff @(posedge clk) begin
    // cnt marks the first normalize cycle, then parks at 1
    if (state == S_FNORM && state_next == S_FNORM) cnt <= 3'd1;
    else if (state != state_next) cnt <= '0;
    else cnt <= cnt + 3'd1;
    if (accept) begin
      ia <= vertex_index;
      ib <= corner_b;
      ic <= corner_c;
    end
    if (state == S_PRD && cnt != 3'd0) begin
      p[cnt[1:0] - 2'd1][0] <= $signed(pos_rdata[3*POS_W-1:2*POS_W]);
      p[cnt[1:0] - 2'd1][1] <= $signed(pos_rdata[2*POS_W-1:POS_W]);
      p[cnt[1:0] - 2'd1][2] <= $signed(pos_rdata[POS_W-1:0]);
    end
    if (state == S_MUL) begin
      if (cnt != 3'd6) prod <= ma * mb;
      if (cnt != 3'd0) begin
        if (cnt[0]) cr[cnt[2:1]] <= VEC_W'(prod);
        else cr[cnt[2:1] - 2'd1] <= cr[cnt[2:1] - 2'd1] - VEC_W'(prod);
      end
    end
    if (state == S_SNORM && nr.done) begin
      vertex_id <= ia;
      used_fallback <= nr.zero;
      normal_x <= nr.zero ? '0 : nr.nx;
      normal_y <= nr.zero ? ONE_Q14 : nr.ny;
      normal_z <= nr.zero ? '0 : nr.nz;
    end
  end

  vna_norm u_norm (
    .clk(clk), .rst(rst), .go(norm_go),
    .vx(vx), .vy(vy), .vz(vz), .res(nr)
  );

  `ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `ASSERT_IMPL(a_go_free, clk, rst, norm_go, !nr.busy)
  `ASSERT_NEXT(a_load_quick, clk, rst, load_we, !busy)
  `ASSERT_IMPL(a_rmw_norm, clk, rst, state == S_RMW, !nr.busy)
endmodule

// ===== rtl/core/vna_norm.sv =====
module vna_norm import vna_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic signed [VEC_W-1:0] vx,
  input  logic signed [VEC_W-1:0] vy,
  input  logic signed [VEC_W-1:0] vz,
  output norm_res_t               res
);
  norm_state_t state, state_next;
  logic [VEC_W-1:0] mag [3];
  logic [2:0] neg;
  logic [59:0] sq;
  logic [60:0] root;
  logic [4:0] k;
  logic [1:0] ci;
  logic [3:0] bc;
  logic [45:0] num, dsh;
  logic [15:0] q;
  logic signed [NRM_W-1:0] n [3];
  logic done, zero;

  logic [VEC_W-1:0] m01, mmax;
  logic [60:0] bitv, trial;
  logic [57:0] sqterm;

  always_comb begin
    m01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    mmax = (m01 > mag[2]) ? m01 : mag[2];
    bitv = 61'(1) << {k, 1'b0};
    trial = root + bitv;
    sqterm = mag[ci][28:0] * mag[ci][28:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      N_IDLE:  if (go) state_next = N_SHIFT;
      N_SHIFT: if (mmax == '0) state_next = N_IDLE;
               else if (mmax < VEC_W'(1 << 29) && mmax >= VEC_W'(1 << 28))
                 state_next = N_SQ;
      N_SQ:    if (ci == 2'd2) state_next = N_SQRT;
      N_SQRT:  if (k == 5'd0) state_next = N_DIV;
      N_DIV:   if (ci == 2'd2 && bc == 4'd0) state_next = N_IDLE;
      default: state_next = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == N_SHIFT && mmax == '0) ||
              (state == N_DIV && ci == 2'd2 && bc == 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        neg <= {vz[VEC_W-1], vy[VEC_W-1], vx[VEC_W-1]};
        mag[0] <= vx[VEC_W-1] ? VEC_W'(-vx) : vx;
        mag[1] <= vy[VEC_W-1] ? VEC_W'(-vy) : vy;
        mag[2] <= vz[VEC_W-1] ? VEC_W'(-vz) : vz;
        ci <= 2'd0;
        sq <= '0;
      end
      N_SHIFT: begin
        zero <= (mmax == '0);
        if (mmax >= VEC_W'(1 << 29)) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (mmax < VEC_W'(1 << 28)) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
      end
      N_SQ: begin
        sq <= sq + 60'(sqterm);
        ci <= (ci == 2'd2) ? 2'd0 : ci + 2'd1;
        root <= '0;
        k <= 5'd29;
      end
      N_SQRT: begin
        // digit-by-digit integer square root, one result bit per cycle
        if ({1'b0, sq} >= trial) begin
          sq <= 60'({1'b0, sq} - trial);
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        k <= k - 5'd1;
        bc <= 4'd15;
        q <= '0;
        dsh <= '0;
      end
      N_DIV: begin
        // round(mag*16384/len) = (mag*32768 + len) / (2*len)
        if (bc == 4'd15 && dsh == '0) begin
          num <= (46'(mag[ci]) << 15) + 46'(root);
          dsh <= 46'(root) << 16;
        end else begin
          if (num >= dsh) num <= num - dsh;
          if (bc == 4'd0) begin
            n[ci] <= neg[ci] ? -$signed((num >= dsh) ? (q | 16'd1) : q)
                             : $signed((num >= dsh) ? (q | 16'd1) : q);
            q <= '0;
            bc <= 4'd15;
            dsh <= '0;
            ci <= ci + 2'd1;
          end else begin
            if (num >= dsh) q <= q | (16'd1 << bc);
            dsh <= dsh >> 1;
            bc <= bc - 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign res.done = done;
  assign res.zero = zero;
  assign res.busy = (state != N_IDLE);
  assign res.nx = n[0];
  assign res.ny = n[1];
  assign res.nz = n[2];
endmodule
